// ===== hdl/greedy_template_token_substituter_top_macros.svh =====
// Assertion macros shared by the checker of the template substituter.
`ifndef GREEDY_TEMPLATE_TOKEN_SUBSTITUTER_TOP_MACROS_SVH
`define GREEDY_TEMPLATE_TOKEN_SUBSTITUTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gts_pkg.sv =====
// Package with codes, constants and controller/datapath interface types.
`default_nettype none
package gts_pkg;

  localparam int DEF_TEMPLATES = 256;
  localparam int DEF_MAX_LEN   = 32;
  localparam int FRAME_STRIDE  = 32;

  localparam logic [15:0] SLOT_WORD = 16'hFFFF;

  // Input operation codes.
  localparam logic [1:0] OP_TOKEN = 2'd0;
  localparam logic [1:0] OP_TMPL  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_ID   = 2'd1;
  localparam logic [1:0] KIND_SLOT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_BASE_ID = 1'b0;
  localparam logic REG_TCOUNT  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_head;
    logic init_search;
    logic rd_len;
    logic t_inc;
    logic start_scan;
    logic rd_scan;
    logic scan_adv;
    logic take_best;
    logic emit_head;
    logic start_emit;
    logic rd_emit;
    logic emit_slot;
    logic j_inc;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic fill_nz;
    logic t_end;
    logic len_bad;
    logic lit_fail;
    logic scan_end;
    logic cand_ok;
    logic found;
    logic has_slot;
    logic is_slot;
    logic emit_end;
    logic out_free;
    logic more_left;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/gts_datapath.sv =====
// Datapath: template memories, lookahead window, search registers and result register.
`default_nettype none
module gts_datapath #(
  parameter int TEMPLATES = 256,
  parameter int MAX_LEN   = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gts_pkg::cmd_t cmd_i,
  output gts_pkg::sts_t      sts_o,
  input  wire logic [1:0]    op_i,
  input  wire logic [15:0]   token_i,
  input  wire logic [7:0]    template_sel_i,
  input  wire logic [4:0]    frame_pos_i,
  input  wire logic [15:0]   frame_word_i,
  input  wire logic [5:0]    template_len_i,
  input  wire logic          cfg_valid_i,
  input  wire logic          cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [15:0]        token_out_o,
  output logic [1:0]         kind_o,
  output logic               last_of_run_o,
  output logic               stream_done_o
);
  import gts_pkg::*;

  localparam int TW    = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
  localparam int CNTW  = (TW + 1 > 9) ? TW + 1 : 9;
  localparam int FAW   = TW + 5;
  localparam int WAW   = $clog2(MAX_LEN);
  localparam int FW    = $clog2(MAX_LEN + 1);

  // Circular index: base plus offset, wrapped once at the window depth.
  function automatic logic [WAW-1:0] wrap(input logic [WAW-1:0] a, input logic [6:0] b);
    logic [6:0] s;
    s = 7'(a) + b;
    if (s >= 7'(MAX_LEN)) s = s - 7'(MAX_LEN);
    return WAW'(s);
  endfunction

  logic [15:0] frame_mem [TEMPLATES*FRAME_STRIDE];
  logic [5:0]  len_mem   [TEMPLATES];
  logic [15:0] win_mem   [MAX_LEN];

  logic [15:0]     base_id_q, frame_rd_q, win_rd_q, head_tok_q;
  logic [8:0]      tcount_q;
  logic [5:0]      len_rd_q, cur_len_q, best_len_q, j_q, cur_last_q, best_last_q;
  logic [CNTW-1:0] t_q;
  logic [TW-1:0]   best_q;
  logic [WAW-1:0]  head_q;
  logic [FW-1:0]   fill_q;
  logic            flush_q, found_q, have_lit_q, cur_slot_q, best_slot_q;
  logic            out_valid_q;

  // Template write decode.
  logic [CNTW-1:0] sel_w;
  logic            sel_ok;
  logic [TW-1:0]   sel_idx;
  assign sel_w   = CNTW'(template_sel_i);
  assign sel_ok  = sel_w < CNTW'(TEMPLATES);
  assign sel_idx = sel_w[TW-1:0];

  // Effective template count, saturated at the table size.
  logic [CNTW-1:0] tc_w, lim;
  assign tc_w = CNTW'(tcount_q);
  assign lim  = (tc_w > CNTW'(TEMPLATES)) ? CNTW'(TEMPLATES) : tc_w;

  // Memory read addresses.
  logic [TW-1:0]  frame_tsel;
  logic [FAW-1:0] frame_raddr;
  logic [WAW-1:0] win_raddr;
  assign frame_tsel  = cmd_i.rd_emit ? best_q : t_q[TW-1:0];
  assign frame_raddr = {frame_tsel, j_q[4:0]};
  assign win_raddr   = cmd_i.rd_head ? head_q : wrap(head_q, 7'(j_q));

  // Template memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && op_i == OP_TMPL && sel_ok) begin
      frame_mem[{sel_idx, frame_pos_i}] <= frame_word_i;
      len_mem[sel_idx] <= template_len_i;
    end
    if (cmd_i.rd_scan || cmd_i.rd_emit) frame_rd_q <= frame_mem[frame_raddr];
    if (cmd_i.rd_len) len_rd_q <= len_mem[t_q[TW-1:0]];
  end

  // Lookahead window memory, written at the tail.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && op_i == OP_TOKEN) win_mem[wrap(head_q, 7'(fill_q))] <= token_i;
    if (cmd_i.rd_head || cmd_i.rd_scan || cmd_i.rd_emit) win_rd_q <= win_mem[win_raddr];
  end

  // Scan checks on the registered frame word and window token.
  logic       slot_w, have_lit_n, final_w;
  logic [5:0] blen;
  assign slot_w     = frame_rd_q == SLOT_WORD;
  assign have_lit_n = have_lit_q | ~slot_w;
  assign blen       = found_q ? best_len_q : 6'd1;
  assign final_w    = !flush_q || (7'(fill_q) == 7'(blen));

  assign sts_o.fill_last = 7'(fill_q) == 7'(MAX_LEN - 1);
  assign sts_o.fill_nz   = fill_q != '0;
  assign sts_o.t_end     = t_q >= lim;
  assign sts_o.len_bad   = len_rd_q == 6'd0 || 7'(len_rd_q) > 7'(fill_q)
                           || len_rd_q <= best_len_q;
  assign sts_o.lit_fail  = !slot_w && ((!have_lit_q && frame_rd_q != head_tok_q)
                           || frame_rd_q != win_rd_q);
  assign sts_o.scan_end  = j_q == cur_len_q - 6'd1;
  assign sts_o.cand_ok   = have_lit_n;
  assign sts_o.found     = found_q;
  assign sts_o.has_slot  = best_slot_q;
  assign sts_o.is_slot   = slot_w;
  assign sts_o.emit_end  = j_q == best_len_q - 6'd1;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.more_left = flush_q && (7'(fill_q) != 7'(blen));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q <= '0;
      tcount_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_ID: base_id_q <= cfg_data_i;
        REG_TCOUNT:  tcount_q  <= cfg_data_i[8:0];
        default:     ;
      endcase
    end
  end

  // Window pointers and search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      found_q     <= 1'b0;
      t_q         <= '0;
      j_q         <= '0;
      best_len_q  <= '0;
      have_lit_q  <= 1'b0;
      cur_slot_q  <= 1'b0;
      best_slot_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        flush_q <= op_i == OP_FLUSH;
        if (op_i == OP_TOKEN) fill_q <= fill_q + FW'(1);
      end
      if (cmd_i.init_search) begin
        t_q        <= '0;
        found_q    <= 1'b0;
        best_len_q <= '0;
      end
      if (cmd_i.t_inc) t_q <= t_q + CNTW'(1);
      if (cmd_i.start_scan || cmd_i.start_emit) j_q <= '0;
      if (cmd_i.start_scan) begin
        have_lit_q <= 1'b0;
        cur_slot_q <= 1'b0;
      end
      if (cmd_i.scan_adv) begin
        j_q        <= j_q + 6'd1;
        have_lit_q <= have_lit_n;
        if (slot_w) cur_slot_q <= 1'b1;
      end
      if (cmd_i.j_inc) j_q <= j_q + 6'd1;
      if (cmd_i.take_best) begin
        found_q     <= 1'b1;
        best_len_q  <= cur_len_q;
        best_slot_q <= cur_slot_q | slot_w;
      end
      if (cmd_i.finish) begin
        head_q <= wrap(head_q, 7'(blen));
        fill_q <= fill_q - FW'(blen);
      end
    end
  end

  // Search payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_search) head_tok_q <= win_rd_q;
    if (cmd_i.start_scan) cur_len_q <= len_rd_q;
    if (cmd_i.scan_adv && slot_w) cur_last_q <= j_q;
    if (cmd_i.take_best) begin
      best_q      <= t_q[TW-1:0];
      best_last_q <= slot_w ? j_q : cur_last_q;
    end
  end

  // Result register; a held result stays until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit_head || cmd_i.emit_slot) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_head) begin
      token_out_o   <= found_q ? 16'(base_id_q + 16'(best_q)) : head_tok_q;
      kind_o        <= found_q ? KIND_ID : KIND_PASS;
      last_of_run_o <= final_w && !(found_q && best_slot_q);
      stream_done_o <= final_w && !(found_q && best_slot_q) && flush_q;
    end else if (cmd_i.emit_slot) begin
      token_out_o   <= win_rd_q;
      kind_o        <= KIND_SLOT;
      last_of_run_o <= final_w && (j_q == best_last_q);
      stream_done_o <= final_w && (j_q == best_last_q) && flush_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/gts_controller.sv =====
// Controller: sequences load, template search, result emission and window advance.
`default_nettype none
module gts_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    op_i,
  input  wire gts_pkg::sts_t sts_i,
  output gts_pkg::cmd_t      cmd_o
);
  import gts_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HEAD_RD  = 4'd1;
  localparam logic [3:0] S_HEAD_CAP = 4'd2;
  localparam logic [3:0] S_LEN_RD   = 4'd3;
  localparam logic [3:0] S_LEN_CHK  = 4'd4;
  localparam logic [3:0] S_SC_RD    = 4'd5;
  localparam logic [3:0] S_SC_CHK   = 4'd6;
  localparam logic [3:0] S_EMIT_ID  = 4'd7;
  localparam logic [3:0] S_EM_RD    = 4'd8;
  localparam logic [3:0] S_EM_CHK   = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if ((op_i == OP_TOKEN && sts_i.fill_last) || (op_i == OP_FLUSH && sts_i.fill_nz))
            state_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        cmd_o.init_search = 1'b1;
        state_d = S_LEN_RD;
      end
      S_LEN_RD: begin
        if (sts_i.t_end) begin
          state_d = S_EMIT_ID;
        end else begin
          cmd_o.rd_len = 1'b1;
          state_d = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        if (sts_i.len_bad) begin
          cmd_o.t_inc = 1'b1;
          state_d = S_LEN_RD;
        end else begin
          cmd_o.start_scan = 1'b1;
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (sts_i.lit_fail) begin
          cmd_o.t_inc = 1'b1;
          state_d = S_LEN_RD;
        end else if (sts_i.scan_end) begin
          cmd_o.take_best = sts_i.cand_ok;
          cmd_o.t_inc = 1'b1;
          state_d = S_LEN_RD;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d = S_SC_RD;
        end
      end
      S_EMIT_ID: begin
        if (sts_i.out_free) begin
          cmd_o.emit_head = 1'b1;
          if (sts_i.found && sts_i.has_slot) begin
            cmd_o.start_emit = 1'b1;
            state_d = S_EM_RD;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_EM_RD: begin
        cmd_o.rd_emit = 1'b1;
        state_d = S_EM_CHK;
      end
      S_EM_CHK: begin
        if (!sts_i.is_slot || sts_i.out_free) begin
          cmd_o.emit_slot = sts_i.is_slot;
          if (sts_i.emit_end) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d = S_EM_RD;
          end
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = sts_i.more_left ? S_HEAD_RD : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== hdl/greedy_template_token_substituter_top.sv =====
// Top level of the greedy template token substituter.
// Input channel (valid/stall): op_i selects a token push, a template word write
// or an end-of-stream flush. Template words go to on-chip frame and length memories.
// Tokens fill a lookahead window; when it holds MAX_LEN tokens, or on a flush until
// it empties, the block decides at the head token and emits results on the output
// channel (valid/stall): a template id and its slot tokens, or one passed token.
// Configuration (valid/ready, always ready): index 0 base_id, index 1 template_count.
// A template write or a token that leaves the window short is taken without a stall.
// A decision examines each template entry, compares the frame words of templates that
// pass the length check, and reads the words of the chosen template again during
// emission when it has a slot; the frame memory is read through a single read port.
// The input stalls for the whole decision; one item is worked on at a time.
// The first result of a decision is loaded into the output register in S_EMIT_ID,
// after the last template entry is checked, as soon as the output register is free.
// Reset clears the window fill, configuration and handshake state; template memory
// needs no clearing pass and must be written before use.
// When the receiver stalls, the held result stays and emission pauses.
`default_nettype none
module greedy_template_token_substituter_top #(
  parameter int TEMPLATES = gts_pkg::DEF_TEMPLATES,
  parameter int MAX_LEN   = gts_pkg::DEF_MAX_LEN
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] token_i,
  input  wire logic [7:0]  template_sel_i,
  input  wire logic [4:0]  frame_pos_i,
  input  wire logic [15:0] frame_word_i,
  input  wire logic [5:0]  template_len_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      token_out_o,
  output logic [1:0]       kind_o,
  output logic             last_of_run_o,
  output logic             stream_done_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import gts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gts_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gts_datapath #(
    .TEMPLATES (TEMPLATES),
    .MAX_LEN   (MAX_LEN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .token_i        (token_i),
    .template_sel_i (template_sel_i),
    .frame_pos_i    (frame_pos_i),
    .frame_word_i   (frame_word_i),
    .template_len_i (template_len_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_out_o    (token_out_o),
    .kind_o         (kind_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o)
  );

endmodule
`default_nettype wire

// ===== hdl/gts_checker.sv =====
// Port-level checker for the template substituter, bound to the top level.
`default_nettype none
`include "greedy_template_token_substituter_top_macros.svh"
module gts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] token_out_o,
  input wire logic [1:0]  kind_o,
  input wire logic        last_of_run_o,
  input wire logic        stream_done_o
);
  import gts_pkg::*;

  // A stalled result stays in place.
  `GTS_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(token_out_o) && $stable(kind_o), "stalled result changed")
  // The end of a stream always closes the run of its item.
  `GTS_ASSERT_SAME(a_done_last, out_valid_o && stream_done_o, last_of_run_o, "stream_done without last_of_run")
  // Only the three defined result kinds appear.
  `GTS_ASSERT_SAME(a_kind, out_valid_o, kind_o == KIND_PASS || kind_o == KIND_ID || kind_o == KIND_SLOT, "undefined result kind")

endmodule

bind greedy_template_token_substituter_top gts_checker u_gts_checker (.*);
`default_nettype wire

// ===== dv/tb_greedy_template_token_substituter_top.sv =====
// Self-checking testbench of the greedy template token substituter.
`default_nettype none
module tb_greedy_template_token_substituter_top;
  import gts_pkg::*;

  localparam int NTPL = DEF_TEMPLATES;
  localparam int WIN  = DEF_MAX_LEN;
  // Templates that the stimulus loads and lets take part in matching.
  localparam int USED_TPL = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] token;
    logic [7:0]  sel;
    logic [4:0]  pos;
    logic [15:0] word;
    logic [5:0]  len;
  } stream_item_t;

  typedef struct packed {
    logic [15:0] tok;
    logic [1:0]  kind;
    logic        last;
    logic        done;
  } emitted_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  op = OP_TOKEN;
  logic [15:0] token = '0;
  logic [7:0]  template_sel = '0;
  logic [4:0]  frame_pos = '0;
  logic [15:0] frame_word = '0;
  logic [5:0]  template_len = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = REG_BASE_ID;
  logic [15:0] cfg_data = '0;
  wire         in_stall_o, out_valid_o, last_of_run_o, stream_done_o, cfg_ready_o;
  wire [15:0]  token_out_o;
  wire [1:0]   kind_o;

  greedy_template_token_substituter_top dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .op_i(op), .token_i(token), .template_sel_i(template_sel),
    .frame_pos_i(frame_pos), .frame_word_i(frame_word), .template_len_i(template_len),
    .out_valid_o, .out_stall_i(out_stall),
    .token_out_o, .kind_o, .last_of_run_o, .stream_done_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predicted block state.
  logic [15:0] frame_mem [NTPL][32];
  logic [5:0]  len_mem [NTPL];
  logic [15:0] lookahead [WIN];
  int          lookahead_fill = 0;
  logic [15:0] base_id_reg = '0;
  logic [8:0]  tcount_reg = '0;

  // Generator view of what has been loaded.
  logic [15:0] gen_word [NTPL][32];
  int          gen_len [NTPL];

  stream_item_t pending_items[$];
  stream_item_t cur_item;
  emitted_t     expected_out[$];
  int           send_idle = 0;
  int           recv_idle = 0;
  int           errors = 0;

  initial forever #5 clk_i = ~clk_i;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic void emit_expected(input logic [15:0] t, input logic [1:0] k);
    emitted_t e;
    e.tok = t; e.kind = k; e.last = 1'b0; e.done = 1'b0;
    expected_out.push_back(e);
  endfunction

  // One greedy decision at the head of the lookahead window.
  function automatic void decide_head();
    int cnt, best, best_len, l, j;
    logic [15:0] head, lit;
    logic have_lit, ok, found;
    cnt = (tcount_reg > NTPL) ? NTPL : tcount_reg;
    head = lookahead[0];
    best = 0; best_len = 0; found = 1'b0;
    for (int t = 0; t < cnt; t++) begin
      l = len_mem[t];
      if (l == 0 || l > lookahead_fill) continue;
      have_lit = 1'b0; lit = '0;
      for (j = 0; j < l; j++)
        if (frame_mem[t][j] != SLOT_WORD) begin
          lit = frame_mem[t][j]; have_lit = 1'b1; break;
        end
      if (!have_lit || lit != head) continue;
      ok = 1'b1;
      for (j = 0; j < l; j++)
        if (frame_mem[t][j] != SLOT_WORD && frame_mem[t][j] != lookahead[j]) ok = 1'b0;
      if (ok && l > best_len) begin
        best = t; best_len = l; found = 1'b1;
      end
    end
    if (found) begin
      emit_expected(base_id_reg + 16'(best), KIND_ID);
      for (j = 0; j < best_len; j++)
        if (frame_mem[best][j] == SLOT_WORD) emit_expected(lookahead[j], KIND_SLOT);
    end else begin
      emit_expected(head, KIND_PASS);
      best_len = 1;
    end
    for (j = 0; j + best_len < lookahead_fill; j++) lookahead[j] = lookahead[j + best_len];
    lookahead_fill -= best_len;
  endfunction

  // Apply one accepted input transaction to the predicted state.
  function automatic void predict_item(input stream_item_t it);
    int prior_cnt;
    prior_cnt = expected_out.size();
    case (it.op)
      OP_TMPL: begin
        frame_mem[it.sel][it.pos] = it.word;
        len_mem[it.sel] = it.len;
      end
      OP_TOKEN: begin
        if (lookahead_fill < WIN) lookahead[lookahead_fill++] = it.token;
        if (lookahead_fill >= WIN) decide_head();
      end
      OP_FLUSH: begin
        while (lookahead_fill > 0) decide_head();
        if (expected_out.size() > prior_cnt) expected_out[expected_out.size() - 1].done = 1'b1;
      end
      default: ;
    endcase
    if (expected_out.size() > prior_cnt) expected_out[expected_out.size() - 1].last = 1'b1;
  endfunction

  // Driver: feeds pending transactions and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) predict_item(cur_item);
      if (!in_valid || !in_stall_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          op <= cur_item.op;
          token <= cur_item.token;
          template_sel <= cur_item.sel;
          frame_pos <= cur_item.pos;
          frame_word <= cur_item.word;
          template_len <= cur_item.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_out.size() == 0) begin
          report($sformatf("unexpected result %h kind %0d", token_out_o, kind_o));
        end else begin
          emitted_t e;
          e = expected_out.pop_front();
          if (token_out_o !== e.tok)
            report($sformatf("token_out %h, predicted %h", token_out_o, e.tok));
          if (kind_o !== e.kind)
            report($sformatf("kind %0d, predicted %0d", kind_o, e.kind));
          if (last_of_run_o !== e.last)
            report($sformatf("last_of_run %b, predicted %b", last_of_run_o, e.last));
          if (stream_done_o !== e.done)
            report($sformatf("stream_done %b, predicted %b", stream_done_o, e.done));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic cfg_write(input logic idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE_ID) base_id_reg = data;
    else tcount_reg = data[8:0];
  endtask

  function automatic void push_item(input logic [1:0] o, input logic [15:0] tk,
                                    input logic [7:0] s, input logic [4:0] p,
                                    input logic [15:0] w, input logic [5:0] l);
    stream_item_t it;
    it.op = o; it.token = tk; it.sel = s; it.pos = p; it.word = w; it.len = l;
    pending_items.push_back(it);
  endfunction

  function automatic void push_word(input int s, input int p, input logic [15:0] w,
                                    input int l);
    push_item(OP_TMPL, 16'($urandom), 8'(s), 5'(p), w, 6'(l));
    if (p < l) gen_word[s][p] = w;
    gen_len[s] = l;
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r < 3) return SLOT_WORD;
    if (r < 9) return 16'($urandom_range(5));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_token();
    int r;
    r = $urandom_range(19);
    if (r < 16) return 16'($urandom_range(5));
    if (r == 16) return SLOT_WORD;
    return 16'($urandom);
  endfunction

  // Load a whole template so that every word under its length is written.
  function automatic void build_template(input int s);
    int r, l;
    r = $urandom_range(19);
    l = (r == 0) ? 0 : (r == 1) ? 32 : $urandom_range(6, 1);
    if (l == 0) push_word(s, $urandom_range(31), pick_word(), 0);
    for (int p = 0; p < l; p++) push_word(s, p, pick_word(), l);
  endfunction

  // Tokens that follow a loaded template, now and then with one token broken.
  function automatic void push_pattern(input int s);
    int bad;
    bad = ($urandom_range(4) == 0) ? $urandom_range(gen_len[s] - 1) : -1;
    for (int p = 0; p < gen_len[s]; p++) begin
      if (p == bad) push_item(OP_TOKEN, pick_token(), 0, 0, 0, 0);
      else if (gen_word[s][p] == SLOT_WORD) push_item(OP_TOKEN, pick_token(), 0, 0, 0, 0);
      else push_item(OP_TOKEN, gen_word[s][p], 0, 0, 0, 0);
    end
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_out.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  localparam logic [15:0] TOK_A = 16'h0011;
  localparam logic [15:0] TOK_B = 16'h0022;

  initial begin
    int cnt_tab[4];
    int n, r, s;
    cnt_tab = '{16, 0, 16, 11};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Give every template that can take part a defined zero length.
    for (int t = 0; t < USED_TPL; t++) push_word(t, 0, 16'h0000, 0);
    wait_idle();

    // Directed: tie between equal lengths, slot-first template, wrap of the id,
    // words beyond the length, empty templates, flush on empty, undefined op.
    cfg_write(REG_BASE_ID, 16'hFFFF);
    cfg_write(REG_TCOUNT, 16'd6);
    push_word(0, 0, TOK_A, 2);  push_word(0, 1, SLOT_WORD, 2);
    push_word(0, 31, TOK_B, 2);
    push_word(1, 0, TOK_A, 3);  push_word(1, 1, SLOT_WORD, 3); push_word(1, 2, TOK_B, 3);
    push_word(2, 0, TOK_A, 3);  push_word(2, 1, TOK_B, 3);     push_word(2, 2, SLOT_WORD, 3);
    push_word(3, 0, TOK_A, 0);
    push_word(4, 0, SLOT_WORD, 2); push_word(4, 1, SLOT_WORD, 2);
    push_word(5, 0, SLOT_WORD, 2); push_word(5, 1, TOK_A, 2);
    push_item(OP_TOKEN, TOK_A, 0, 0, 0, 0);
    push_item(OP_TOKEN, TOK_B, 0, 0, 0, 0);
    push_item(OP_TOKEN, TOK_B, 0, 0, 0, 0);
    push_item(OP_TOKEN, TOK_A, 0, 0, 0, 0);
    push_item(OP_TOKEN, TOK_A, 0, 0, 0, 0);
    push_item(OP_TOKEN, 16'hFFFF, 0, 0, 0, 0);
    push_item(OP_TOKEN, 16'h0000, 0, 0, 0, 0);
    push_item(OP_FLUSH, 0, 0, 0, 0, 0);
    push_item(OP_FLUSH, 0, 0, 0, 0, 0);
    push_item(2'd3, 16'hFFFF, 8'hFF, 5'h1F, 16'hFFFF, 6'h3F);
    wait_idle();

    // Random phases with changing configuration and idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 64; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 64; end
        default: begin send_idle = 33; recv_idle = 33; end
      endcase
      cfg_write(REG_BASE_ID, (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : 16'($urandom));
      cfg_write(REG_TCOUNT, 16'(cnt_tab[ph]));
      build_template($urandom_range(USED_TPL - 1));
      build_template($urandom_range(USED_TPL - 1));
      n = 0;
      while (n < 14) begin
        r = $urandom_range(99);
        s = $urandom_range(USED_TPL - 1);
        if (r < 55) begin
          if (gen_len[s] > 0) begin push_pattern(s); n++; end
        end else if (r < 85) begin
          push_item(OP_TOKEN, pick_token(), 0, 0, 0, 0); n++;
        end else if (r < 90) begin
          build_template(s);
        end else if (r < 93) begin
          push_item(2'd3, 16'($urandom), 8'($urandom), 5'($urandom), 16'($urandom),
                    6'($urandom));
        end else if (r < 97) begin
          push_item(OP_FLUSH, 0, 0, 0, 0, 0); n++;
        end else if (gen_len[s] > 0 && gen_len[s] < 32) begin
          push_word(s, $urandom_range(31, gen_len[s]), 16'($urandom), gen_len[s]);
        end
      end
      push_item(OP_FLUSH, 0, 0, 0, 0, 0);
      wait_idle();
    end

    if (errors == 0) $display("[greedy_template_token_substituter_top] OK");
    else $display("[greedy_template_token_substituter_top] ERROR");
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("[greedy_template_token_substituter_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
